>>> hdl/ttme_pkg.sv
// Package with types and constants for the tap tempo estimator.
package ttme_pkg;

  localparam int unsigned HistDepth = 16;
  localparam int unsigned HistAw    = $clog2(HistDepth);
  localparam int unsigned TimeW     = 32;
  localparam int unsigned TempoW    = 14;
  localparam int unsigned CountW    = $clog2(HistDepth + 1);
  localparam int unsigned NumW      = 30;
  localparam logic [NumW-1:0] TenthsNum = NumW'(600000000);
  // The rounded dividend N + median/2 stays below 2^33.
  localparam int unsigned DivW      = TimeW + 1;

  typedef enum logic [1:0] {
    CFG_GAP     = 2'd0,
    CFG_FLOOR   = 2'd1,
    CFG_CEILING = 2'd2,
    CFG_READY   = 2'd3
  } cfg_idx_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LAST_RD,
    ST_LAST_WT,
    ST_STORE,
    ST_GAP_RD,
    ST_GAP_WT,
    ST_GAP_CAP,
    ST_RANK,
    ST_DIV,
    ST_FINISH,
    ST_OUT
  } state_e;

  typedef struct packed {
    logic       kind;
    logic [31:0] tap_time_us;
  } in_item_t;

  typedef struct packed {
    logic [TempoW-1:0] tempo_tenths;
    logic [CountW-1:0] tap_count;
    logic              estimate_valid;
    logic              ready_res;
  } out_item_t;

  typedef struct packed {
    logic latch_in;
    logic clear_hist;
    logic rd_last;
    logic store_tap;
    logic gap_rd;
    logic gap_cap;
    logic rank_step;
    logic div_start;
    logic div_step;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic is_clear;
    logic gap_over;
    logic have_hist;
    logic need_est;
    logic gaps_done;
    logic rank_done;
    logic div_done;
  } sts_t;

endpackage

>>> hdl/ttme_ram.sv
// Generic single-port-write, single-read RAM with registered read data.
module ttme_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_o <= mem_q[raddr_i];
  end
endmodule

>>> hdl/ttme_ctrl.sv
// Controller state machine for the tap tempo estimator.
module ttme_ctrl import ttme_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  output logic out_valid_o,
  input  logic out_stall_i,
  output logic busy_o,
  input  sts_t sts_i,
  output cmd_t cmd_o
);
  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    in_stall_o  = 1'b1;
    out_valid_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.latch_in = 1'b1;
          state_d = ST_LAST_RD;
        end
      end
      ST_LAST_RD: begin
        if (sts_i.is_clear) begin
          cmd_o.clear_hist = 1'b1;
          state_d = ST_OUT;
        end else begin
          cmd_o.rd_last = 1'b1;
          state_d = ST_LAST_WT;
        end
      end
      ST_LAST_WT: begin
        state_d = ST_STORE;
      end
      ST_STORE: begin
        if (sts_i.have_hist && sts_i.gap_over) cmd_o.clear_hist = 1'b1;
        cmd_o.store_tap = 1'b1;
        state_d = ST_GAP_RD;
      end
      ST_GAP_RD: begin
        if (!sts_i.need_est) begin
          state_d = ST_OUT;
        end else if (sts_i.gaps_done) begin
          state_d = ST_RANK;
        end else begin
          cmd_o.gap_rd = 1'b1;
          state_d = ST_GAP_WT;
        end
      end
      ST_GAP_WT: begin
        // Hold the read address so the data seen at capture is the older tap.
        cmd_o.gap_rd = 1'b1;
        state_d = ST_GAP_CAP;
      end
      ST_GAP_CAP: begin
        cmd_o.gap_cap = 1'b1;
        state_d = ST_GAP_RD;
      end
      ST_RANK: begin
        if (sts_i.rank_done) begin
          cmd_o.div_start = 1'b1;
          state_d = ST_DIV;
        end else begin
          cmd_o.rank_step = 1'b1;
        end
      end
      ST_DIV: begin
        if (sts_i.div_done) begin
          state_d = ST_FINISH;
        end else begin
          cmd_o.div_step = 1'b1;
        end
      end
      ST_FINISH: begin
        cmd_o.finish = 1'b1;
        state_d = ST_OUT;
      end
      ST_OUT: begin
        out_valid_o = 1'b1;
        if (!out_stall_i) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign busy_o = (state_q != ST_IDLE);

  a_out_only_in_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o) else $error("input taken while result pending");
  a_store_after_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.store_tap |-> $past(state_q) == ST_LAST_WT) else $error("store out of order");
  a_div_then_finish: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.finish |=> out_valid_o) else $error("finish not followed by output");
endmodule

>>> hdl/ttme_dp.sv
// Datapath: tap history, gap list, rank-based median select and divider.
module ttme_dp import ttme_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  in_item_t          in_item_i,
  input  logic [31:0]       gap_timeout_i,
  input  logic [TempoW-1:0] floor_i,
  input  logic [TempoW-1:0] ceiling_i,
  input  logic [4:0]        ready_cnt_i,
  input  cmd_t              cmd_i,
  output sts_t              sts_o,
  output out_item_t         out_item_o
);
  logic              kind_q;
  logic [TimeW-1:0]  now_q;
  logic [HistAw-1:0] head_q;
  logic [CountW-1:0] count_q;
  logic [TempoW-1:0] est_q;

  // Gap list of up to HistDepth-1 intervals, each read at a fixed place.
  logic [TimeW-1:0]  gaps_q [HistDepth];
  logic [HistAw-1:0] gidx_q;     // next interval to fetch
  logic [TimeW-1:0]  prev_q;     // newer tap time of the pending interval

  logic [HistAw-1:0] ridx_q;     // candidate under test
  logic [TimeW-1:0]  med_q;
  logic              found_q;

  logic [DivW-1:0]   rem_q;
  logic [TimeW-1:0]  dvs_q;      // divisor: the median
  logic [DivW-1:0]   quo_q;      // dividend bits shift out as quotient bits shift in
  logic [5:0]        dcnt_q;

  logic [HistAw-1:0] raddr;
  logic [TimeW-1:0]  rdata;
  logic              we;
  logic [CountW-1:0] nint;       // intervals = count-1

  assign nint = count_q - CountW'(1);

  // The newest tap sits at head-1, so interval i needs the tap at head-2-i.
  always_comb begin
    raddr = head_q - HistAw'(1);
    if (cmd_i.gap_rd) raddr = head_q - HistAw'(gidx_q) - HistAw'(2);
  end

  assign we = cmd_i.store_tap;

  ttme_ram #(.Width(TimeW), .Depth(HistDepth)) u_hist (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (cmd_i.clear_hist ? '0 : head_q),
    .wdata_i (now_q),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // Count of gaps strictly less, and less-or-equal, than the candidate.
  logic [CountW-1:0] n_lt, n_le;
  logic [TimeW-1:0]  cand;
  assign cand = gaps_q[ridx_q];
  always_comb begin
    n_lt = '0;
    n_le = '0;
    for (int k = 0; k < HistDepth; k++) begin
      if (CountW'(k) < nint) begin
        if (gaps_q[k] < cand) n_lt = n_lt + CountW'(1);
        if (gaps_q[k] <= cand) n_le = n_le + CountW'(1);
      end
    end
  end
  logic [CountW-1:0] mid;
  assign mid = nint >> 1;
  logic is_med;
  assign is_med = (n_lt <= mid) && (n_le > mid);

  logic [DivW-1:0] shifted;
  logic [DivW:0]   trial;
  assign shifted = {rem_q[DivW-2:0], quo_q[DivW-1]};
  assign trial   = {1'b0, shifted} - {2'b00, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      count_q <= '0;
      est_q   <= '0;
    end else begin
      if (cmd_i.clear_hist) begin
        head_q  <= '0;
        count_q <= '0;
        est_q   <= '0;
      end
      if (cmd_i.store_tap) begin
        head_q <= (cmd_i.clear_hist ? '0 : head_q) + HistAw'(1);
        if (cmd_i.clear_hist) count_q <= CountW'(1);
        else if (count_q < CountW'(HistDepth)) count_q <= count_q + CountW'(1);
      end
      if (cmd_i.finish) begin
        if (med_q == '0) est_q <= ceiling_i;
        else begin
          logic [TempoW-1:0] t;
          t = (quo_q > DivW'(ceiling_i)) ? ceiling_i : TempoW'(quo_q);
          if (quo_q < DivW'(floor_i)) t = floor_i;
          if (t > ceiling_i) t = ceiling_i;
          est_q <= t;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch_in) begin
      kind_q <= in_item_i.kind;
      now_q  <= in_item_i.tap_time_us;
    end
    if (cmd_i.store_tap) begin
      gidx_q    <= '0;
      prev_q    <= now_q;
      ridx_q    <= '0;
    end
    if (cmd_i.gap_cap) begin
      gaps_q[gidx_q] <= prev_q - rdata;
      prev_q <= rdata;
      gidx_q <= gidx_q + HistAw'(1);
    end
    if (cmd_i.rank_step) begin
      if (is_med) begin
        med_q   <= cand;
        found_q <= 1'b1;
      end
      ridx_q <= ridx_q + HistAw'(1);
    end else if (cmd_i.store_tap) begin
      found_q <= 1'b0;
    end
    if (cmd_i.div_start) begin
      // Restoring division of N + med/2 by med, one quotient bit per step.
      rem_q  <= '0;
      quo_q  <= DivW'(TenthsNum) + DivW'(med_q >> 1);
      dvs_q  <= med_q;
      dcnt_q <= 6'(DivW);
    end
    if (cmd_i.div_step) begin
      if (!trial[DivW]) begin
        rem_q <= trial[DivW-1:0];
        quo_q <= {quo_q[DivW-2:0], 1'b1};
      end else begin
        rem_q <= shifted;
        quo_q <= {quo_q[DivW-2:0], 1'b0};
      end
      dcnt_q <= dcnt_q - 6'd1;
    end
  end

  logic [TimeW-1:0] gap_now;
  assign gap_now = now_q - rdata;

  assign sts_o.is_clear  = kind_q;
  assign sts_o.gap_over  = gap_now > gap_timeout_i;
  assign sts_o.have_hist = count_q != '0;
  assign sts_o.need_est  = count_q >= CountW'(2);
  assign sts_o.gaps_done = CountW'(gidx_q) >= nint || gidx_q == HistAw'(HistDepth - 1);
  assign sts_o.rank_done = found_q;
  assign sts_o.div_done  = dcnt_q == '0;

  logic vld;
  assign vld = count_q >= CountW'(2);
  assign out_item_o.tempo_tenths   = vld ? est_q : '0;
  assign out_item_o.tap_count      = count_q;
  assign out_item_o.estimate_valid = vld;
  assign out_item_o.ready_res      = vld && (count_q >= ready_cnt_i);

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CountW'(HistDepth)) else $error("count overflow");
  a_est_zero_on_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.clear_hist && !cmd_i.store_tap |=> est_q == '0) else $error("clear missed");
  a_ready_needs_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_item_o.ready_res |-> out_item_o.estimate_valid) else $error("ready without valid");
endmodule

>>> hdl/tap_tempo_median_estimator.sv
// Tap tempo estimator: one result per item, upper-median interval to tempo.
// A clear item goes straight to the result; a tap that leaves fewer than two taps skips the
// estimate; otherwise the result follows the interval fetch, up to n rank steps for n
// intervals and the 33-step divider.
// One item at a time; a new item can be taken in the cycle after the result leaves.
// Reset clears history count, head, estimate and sets registers to default values.
module tap_tempo_median_estimator import ttme_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_item_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_data_o,
  input  logic      cfg_valid_i,
  output logic      cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i
);
  logic [31:0]       gap_q;
  logic [TempoW-1:0] floor_q, ceil_q;
  logic [4:0]        rdy_q;
  logic busy;
  cmd_t cmd;
  sts_t sts;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gap_q   <= 32'd2000000;
      floor_q <= TempoW'(200);
      ceil_q  <= TempoW'(4000);
      rdy_q   <= 5'd4;
    end else if (cfg_valid_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_GAP:     gap_q   <= cfg_data_i;
        CFG_FLOOR:   floor_q <= cfg_data_i[TempoW-1:0];
        CFG_CEILING: ceil_q  <= cfg_data_i[TempoW-1:0];
        CFG_READY:   rdy_q   <= cfg_data_i[4:0];
        default: ;
      endcase
    end
  end

  ttme_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .out_valid_o, .out_stall_i,
    .busy_o(busy), .sts_i(sts), .cmd_o(cmd)
  );

  ttme_dp u_dp (
    .clk_i, .rst_ni, .in_item_i(in_data_i), .gap_timeout_i(gap_q),
    .floor_i(floor_q), .ceiling_i(ceil_q), .ready_cnt_i(rdy_q),
    .cmd_i(cmd), .sts_o(sts), .out_item_o(out_data_o)
  );

  a_busy_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> busy) else $error("result while idle");
endmodule
